FILE: hw/rtl/crc16_frame_checker_core_assert.svh
`ifndef CRC16_FRAME_CHECKER_CORE_ASSERT_SVH
`define CRC16_FRAME_CHECKER_CORE_ASSERT_SVH

// Implication checked on the same edge; needs clk and rst_n in scope.
`define CRCFC_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Implication checked on the following edge.
`define CRCFC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Condition that must never be seen.
`define CRCFC_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/crcfc_pkg.sv
package crcfc_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERLONG = 2'd3
  } frame_status_t;

  typedef enum logic {
    RK_PAYLOAD = 1'b0,
    RK_STATUS  = 1'b1
  } result_kind_t;

  // Request passed from the front end to the CRC back end
  typedef struct packed {
    logic        fold;
    logic [7:0]  fold_byte;
    logic        last;
    logic        overlong;
    logic        short_frame;
    logic [7:0]  plen;
    logic [15:0] trailer;
  } cmd_t;

endpackage

FILE: hw/rtl/crc16_frame_checker_core.sv
// CRC-16/MODBUS frame checker. Bytes arrive on the in_ channel, with
// in_last_byte set on the final byte of a frame. The two newest bytes are held
// back as the trailer; each older byte leaves on the out_ channel as a payload
// result (kind 0) and is folded into the CRC (reflected 0xA001, init 0xFFFF).
// The final byte adds a status result (kind 1): good, mismatch, too short
// (fewer than two bytes) or overlong (bytes beyond MAX_FRAME_BYTES, which are
// dropped), with the payload length and the computed CRC. One byte is taken
// per cycle while the queue is not full; a byte that both releases payload and
// closes the frame yields two results, payload then status, from the single
// output register, and a four-entry queue between the byte classifier and the
// CRC unit absorbs that burst.
module crc16_frame_checker_core import crcfc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_payload_length,
  output logic [15:0] out_computed_crc,
  output logic        out_last_of_run
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_head;

  crcfc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd)
  );

  crcfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .cmd_in    (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .head_valid(q_head_valid),
    .head      (q_head)
  );

  crcfc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (q_head_valid),
    .head              (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_status  (out_frame_status),
    .out_payload_length(out_payload_length),
    .out_computed_crc  (out_computed_crc),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

FILE: hw/rtl/crcfc_front.sv
module crcfc_front import crcfc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);

  logic [7:0]       older_r, older_nxt;
  logic [7:0]       newer_r, newer_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovl_r, ovl_nxt;

  logic             take;
  logic             room;
  logic [EXT_W-1:0] cnt_ext;
  logic [EXT_W-1:0] plen_ext;

  assign in_stall = q_full;

  always_comb begin
    take      = in_valid && !q_full;
    room      = count_r < CNT_MAX;
    older_nxt = older_r;
    newer_nxt = newer_r;
    count_nxt = count_r;
    ovl_nxt   = ovl_r;

    if (take) begin
      if (room) begin
        older_nxt = newer_r;
        newer_nxt = in_data_byte;
        count_nxt = count_r + 1'b1;
      end else begin
        ovl_nxt = 1'b1;
      end
    end

    cnt_ext  = EXT_W'(count_nxt);
    plen_ext = (cnt_ext >= EXT_W'(2)) ? cnt_ext - EXT_W'(2) : '0;

    q_cmd.fold        = room && (count_r >= CNT_TWO);
    q_cmd.fold_byte   = older_r;
    q_cmd.last        = in_last_byte;
    q_cmd.overlong    = ovl_nxt;
    q_cmd.short_frame = count_nxt < CNT_TWO;
    q_cmd.plen        = (plen_ext > EXT_W'(255)) ? 8'hFF : plen_ext[7:0];
    q_cmd.trailer     = {newer_nxt, older_nxt};

    // Only requests that release a byte or close the frame reach the back end
    q_push = take && (q_cmd.fold || in_last_byte);

    // Clear for the next frame
    if (take && in_last_byte) begin
      older_nxt = '0;
      newer_nxt = '0;
      count_nxt = '0;
      ovl_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      newer_r <= '0;
      count_r <= '0;
      ovl_r   <= 1'b0;
    end else begin
      older_r <= older_nxt;
      newer_r <= newer_nxt;
      count_r <= count_nxt;
      ovl_r   <= ovl_nxt;
    end
  end

endmodule

FILE: hw/rtl/crcfc_queue.sv
`include "crc16_frame_checker_core_assert.svh"

module crcfc_queue import crcfc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t cmd_in,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r, fill_nxt;

  assign full       = fill_r == QCNT_W'(QDEPTH);
  assign head_valid = fill_r != '0;
  assign head       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cmd_in;
    end
  end

  `CRCFC_ASSERT_NEVER(a_pop_empty, pop && !head_valid, "queue popped while empty")
  `CRCFC_ASSERT_NEVER(a_push_full, push && full, "queue pushed while full")
  `CRCFC_ASSERT_NEVER(a_fill_bound, fill_r > QCNT_W'(QDEPTH), "queue fill beyond depth")

endmodule

FILE: hw/rtl/crcfc_back.sv
`include "crc16_frame_checker_core_assert.svh"

module crcfc_back import crcfc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cmd_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_payload_length,
  output logic [15:0] out_computed_crc,
  output logic        out_last_of_run
);

  // Reflected CRC-16 over one byte, one bit per step
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [15:0]   crc_r, crc_nxt;
  logic          fold_done_r, fold_done_nxt;
  logic          out_valid_r, out_valid_nxt;
  result_kind_t  kind_r, kind_nxt;
  logic [7:0]    byte_r, byte_nxt;
  frame_status_t status_r, status_nxt;
  logic [7:0]    plen_r, plen_nxt;
  logic [15:0]   ocrc_r, ocrc_nxt;
  logic          lor_r, lor_nxt;

  logic          load;
  logic          do_fold;
  logic [15:0]   folded;

  always_comb begin
    load          = head_valid && (!out_valid_r || !out_stall);
    do_fold       = head.fold && !fold_done_r;
    folded        = crc_fold(crc_r, head.fold_byte);
    pop           = 1'b0;
    crc_nxt       = crc_r;
    fold_done_nxt = fold_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    status_nxt    = status_r;
    plen_nxt      = plen_r;
    ocrc_nxt      = ocrc_r;
    lor_nxt       = lor_r;

    if (load) begin
      out_valid_nxt = 1'b1;
      if (do_fold) begin
        kind_nxt   = RK_PAYLOAD;
        byte_nxt   = head.fold_byte;
        status_nxt = ST_GOOD;
        plen_nxt   = '0;
        ocrc_nxt   = '0;
        lor_nxt    = !head.last;
        crc_nxt    = folded;
        // Hold the request so its status goes out next
        if (head.last) begin
          fold_done_nxt = 1'b1;
        end else begin
          pop = 1'b1;
        end
      end else begin
        kind_nxt = RK_STATUS;
        byte_nxt = '0;
        if (head.overlong) begin
          status_nxt = ST_OVERLONG;
        end else if (head.short_frame) begin
          status_nxt = ST_SHORT;
        end else if (crc_r == head.trailer) begin
          status_nxt = ST_GOOD;
        end else begin
          status_nxt = ST_MISMATCH;
        end
        plen_nxt      = head.plen;
        ocrc_nxt      = crc_r;
        lor_nxt       = 1'b1;
        crc_nxt       = CRC_INIT;
        fold_done_nxt = 1'b0;
        pop           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      fold_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      fold_done_r <= fold_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    plen_r   <= plen_nxt;
    ocrc_r   <= ocrc_nxt;
    lor_r    <= lor_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_frame_status   = status_r;
  assign out_payload_length = plen_r;
  assign out_computed_crc   = ocrc_r;
  assign out_last_of_run    = lor_r;

  `CRCFC_ASSERT_IMPL(a_payload_clean, out_valid_r && kind_r == RK_PAYLOAD,
    status_r == ST_GOOD && plen_r == 8'd0 && ocrc_r == 16'd0, "payload result has status fields")
  `CRCFC_ASSERT_IMPL(a_short_crc, out_valid_r && kind_r == RK_STATUS && status_r == ST_SHORT,
    ocrc_r == CRC_INIT && plen_r == 8'd0, "short frame reports folded crc or length")
  `CRCFC_ASSERT_IMPL(a_fold_phase, fold_done_r, head_valid && head.last, "fold phase without frame end")

endmodule

FILE: verif/tb.sv
module tb;
  import crcfc_pkg::*;

  localparam int FRAME_CAP = 256;
  localparam int IDLE_PCT = 38;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int TARGET_BYTES = 1800;

  typedef struct packed {
    result_kind_t  kind;
    logic [7:0]    pbyte;
    frame_status_t status;
    logic [7:0]    plen;
    logic [15:0]   crc;
    logic          last_run;
  } frame_result_t;

  class frame_ledger;
    frame_result_t due_results[$];
    logic [15:0]   crc_acc;
    logic [7:0]    older_byte;
    logic [7:0]    newer_byte;
    int unsigned   byte_count;
    bit            overflowed;
    int            fails;

    function new();
      fails = 0;
      restart();
    endfunction

    function void restart();
      crc_acc = CRC_INIT;
      older_byte = 8'h00;
      newer_byte = 8'h00;
      byte_count = 0;
      overflowed = 1'b0;
    endfunction

    static function logic [15:0] fold(logic [15:0] acc, logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void push(result_kind_t kind, logic [7:0] pb, frame_status_t st,
                       logic [7:0] pl, logic [15:0] crc);
      frame_result_t r;
      r.kind = kind;
      r.pbyte = pb;
      r.status = st;
      r.plen = pl;
      r.crc = crc;
      r.last_run = 1'b0;
      due_results.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int unsigned   first_new;
      int unsigned   plen;
      frame_status_t st;
      frame_result_t r;
      first_new = due_results.size();
      if (byte_count < FRAME_CAP) begin
        // release the older held byte once two are held
        if (byte_count >= 2) begin
          crc_acc = fold(crc_acc, older_byte);
          push(RK_PAYLOAD, older_byte, ST_GOOD, 8'h00, 16'h0000);
        end
        older_byte = newer_byte;
        newer_byte = b;
        byte_count++;
      end else begin
        overflowed = 1'b1;
      end
      if (last) begin
        plen = (byte_count >= 2) ? byte_count - 2 : 0;
        if (plen > 255) plen = 255;
        if (overflowed) st = ST_OVERLONG;
        else if (byte_count < 2) st = ST_SHORT;
        else if (crc_acc == {newer_byte, older_byte}) st = ST_GOOD;
        else st = ST_MISMATCH;
        push(RK_STATUS, 8'h00, st, 8'(plen), crc_acc);
        restart();
      end
      if (due_results.size() > first_new) begin
        r = due_results.pop_back();
        r.last_run = 1'b1;
        due_results.push_back(r);
      end
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("mismatch: %s", msg);
    endtask

    task match_result(frame_result_t got);
      frame_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result kind %0d with nothing due", got.kind));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("result kind %0d, want %0d", got.kind, want.kind));
      if (got.pbyte !== want.pbyte)
        report($sformatf("payload byte %h, want %h", got.pbyte, want.pbyte));
      if (got.status !== want.status)
        report($sformatf("frame status %0d, want %0d", got.status, want.status));
      if (got.plen !== want.plen)
        report($sformatf("payload length %0d, want %0d", got.plen, want.plen));
      if (got.crc !== want.crc)
        report($sformatf("computed crc %h, want %h", got.crc, want.crc));
      if (got.last_run !== want.last_run)
        report($sformatf("last of run %b, want %b", got.last_run, want.last_run));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_payload_length;
  logic [15:0] out_computed_crc;
  logic        out_last_of_run;

  frame_ledger   ledger;
  frame_result_t seen;
  bit            calm = 1'b0;
  int            sent = 0;
  int unsigned   cycles = 0;

  crc16_frame_checker_core #(
    .MAX_FRAME_BYTES(FRAME_CAP)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_payload_byte   (out_payload_byte),
    .out_frame_status   (out_frame_status),
    .out_payload_length (out_payload_length),
    .out_computed_crc   (out_computed_crc),
    .out_last_of_run    (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ledger.take_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) begin
        seen.kind = result_kind_t'(out_result_kind);
        seen.pbyte = out_payload_byte;
        seen.status = frame_status_t'(out_frame_status);
        seen.plen = out_payload_length;
        seen.crc = out_computed_crc;
        seen.last_run = out_last_of_run;
        ledger.match_result(seen);
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Payload then a CRC trailer, low byte first; fill below zero means random bytes.
  task automatic send_frame(input int plen, input bit corrupt, input int fill);
    logic [15:0] acc;
    logic [7:0]  b;
    logic [7:0]  lo;
    logic [7:0]  hi;
    acc = CRC_INIT;
    for (int k = 0; k < plen; k++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      acc = frame_ledger::fold(acc, b);
      send_byte(b, 1'b0);
    end
    lo = acc[7:0];
    hi = acc[15:8];
    if (corrupt) begin
      if ($urandom_range(1) == 1) lo ^= 8'(1 << $urandom_range(7));
      else hi ^= 8'(1 << $urandom_range(7));
    end
    send_byte(lo, 1'b0);
    send_byte(hi, 1'b1);
  endtask

  task automatic send_raw(input int n, input bit noisy);
    logic last;
    for (int k = 0; k < n; k++) begin
      last = noisy ? ($urandom_range(3) == 0) : (k == n - 1);
      send_byte(8'($urandom), last);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (ledger.due_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    int  pick;
    int  plen;
    bit  big_done;
    ledger = new();
    big_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_byte(8'h5A, 1'b1);
    // two-byte frames: trailer against the initial CRC
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_frame(1, 1'b0, 8'h00);
    send_frame(3, 1'b0, 8'hFF);
    send_frame(2, 1'b1, -1);
    send_frame(4, 1'b0, -1);
    wait_drained();

    while (sent < TARGET_BYTES) begin
      if (!big_done && sent >= 450) begin
        // close any open frame so the next one starts empty
        send_byte(8'($urandom), 1'b1);
        // full capacity, then overlong by one and by many
        send_frame(FRAME_CAP - 2, 1'b0, -1);
        send_raw(FRAME_CAP + 1, 1'b0);
        send_raw(FRAME_CAP + 44, 1'b0);
        wait_drained();
        big_done = 1'b1;
      end
      calm = (sent >= 1000 && sent < 1300);
      pick = $urandom_range(99);
      plen = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
      if (pick < 60) send_frame(plen, 1'b0, -1);
      else if (pick < 72) send_frame(plen, 1'b1, -1);
      else if (pick < 80) send_byte(8'($urandom), 1'b1);
      else if (pick < 90) send_raw($urandom_range(16, 1), 1'b1);
      else send_raw($urandom_range(8, 2), 1'b0);
    end
    calm = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (ledger.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
